/* design/gvn_pkg.sv */
// Shared types, constants and helper functions of the grid vertex normal stencil.
package gvn_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int COORD_W    = 16;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int NORM_W     = 2 * DIFF_W;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = 16;
    localparam int GW_W       = 11;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_W    = $clog2(Q_DEPTH);
    localparam int Q_LVL_W    = Q_PTR_W + 1;
    localparam int VTX_W      = 3 * COORD_W;
    localparam int OUT_DATA_W = 96;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = CFG_IDX_W'(1);

    // Result slots of one vertex, in emission order.
    localparam int RES_UP    = 0;  // normal of the row above
    localparam int RES_LEFT  = 1;  // last row: normal of the left neighbor
    localparam int RES_SELF  = 2;  // last row, last column: own normal
    localparam int RES_N     = 3;

    typedef struct packed {
        logic signed [COORD_W-1:0] z;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } vtx_t;

    typedef struct packed {
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dzx;
        logic signed [DIFF_W-1:0] dy;
        logic signed [DIFF_W-1:0] dzy;
    } diff_t;

    typedef struct packed {
        diff_t [RES_N-1:0]  res;
        logic [RES_N-1:0]   mask;
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
    } rec_t;

    typedef struct packed {
        logic [Q_LVL_W-1:0] level;
        logic               head_valid;
    } q_stat_t;

    function automatic logic signed [DIFF_W-1:0] sub_ext(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        return {a[COORD_W-1], a} - {b[COORD_W-1], b};
    endfunction

    // Banks rotate among three roles; index arithmetic is modulo three.
    function automatic logic [1:0] bank_inc(input logic [1:0] b);
        return (b == 2'd2) ? 2'd0 : b + 2'd1;
    endfunction

    function automatic logic [1:0] bank_dec(input logic [1:0] b);
        return (b == 2'd0) ? 2'd2 : b - 2'd1;
    endfunction

endpackage

/* design/gvn_line_ram.sv */
// Simple dual-port line store with registered read data.
module gvn_line_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 48
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* design/gvn_front.sv */
// Front end: accepts vertices, keeps row stores and windows, forms the differences.
module gvn_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [gvn_pkg::VTX_W-1:0]         s_tdata,
    input  logic                              cfg_valid,
    input  logic [gvn_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gvn_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  gvn_pkg::q_stat_t                  q_stat,
    output logic                              push,
    output gvn_pkg::rec_t                     push_rec
);

    logic [gvn_pkg::GW_W-1:0]  grid_width_reg;
    logic [gvn_pkg::ROW_W-1:0] grid_height_reg;
    logic [gvn_pkg::COL_W-1:0] col_reg, col_next;
    logic [gvn_pkg::ROW_W-1:0] row_reg, row_next;
    logic [1:0]                rot_reg, rot_next;
    logic [gvn_pkg::GW_W-1:0]  w_eff;
    logic [gvn_pkg::COL_W-1:0] w_m1;
    logic [gvn_pkg::ROW_W-1:0] h_m1;
    logic                      accept, col_end, cfg_hit;
    logic [gvn_pkg::COL_W-1:0] prev_addr;
    logic [gvn_pkg::VTX_W-1:0] rd [3];

    // Stage one: the accepted vertex meets its read data.
    logic                      v1_reg;
    gvn_pkg::vtx_t             vtx1_reg;
    logic [gvn_pkg::COL_W-1:0] col1_reg;
    logic [gvn_pkg::ROW_W-1:0] row1_reg;
    logic                      up1_reg, row_is1_reg, first1_reg, last1_reg, is1_reg, drain1_reg;
    logic [1:0]                prev_sel1_reg, old_sel1_reg;

    gvn_pkg::vtx_t p0_reg, pp1_reg, cur_m1_reg, cur_m2_reg;
    gvn_pkg::vtx_t cur_first_reg, prev_first_reg;
    gvn_pkg::vtx_t nw_m1, nw_0, nw_p1, rd_old, up_ref, left_ref;

    always_comb begin
        if (grid_width_reg < gvn_pkg::GW_W'(2)) begin
            w_eff = gvn_pkg::GW_W'(2);
        end else if (grid_width_reg > gvn_pkg::GW_W'(gvn_pkg::MAX_WIDTH)) begin
            w_eff = gvn_pkg::GW_W'(gvn_pkg::MAX_WIDTH);
        end else begin
            w_eff = grid_width_reg;
        end
    end
    assign w_m1 = gvn_pkg::COL_W'(w_eff - gvn_pkg::GW_W'(1));
    assign h_m1 = (grid_height_reg < gvn_pkg::ROW_W'(2)) ? gvn_pkg::ROW_W'(1)
                                                         : grid_height_reg - gvn_pkg::ROW_W'(1);

    assign s_tready = (q_stat.level + gvn_pkg::Q_LVL_W'(v1_reg))
                      < gvn_pkg::Q_LVL_W'(gvn_pkg::Q_DEPTH);
    assign accept   = s_tvalid && s_tready;
    assign col_end  = (col_reg == w_m1);
    assign cfg_hit  = cfg_valid && (cfg_index == gvn_pkg::REG_GRID_WIDTH ||
                                    cfg_index == gvn_pkg::REG_GRID_HEIGHT);
    assign prev_addr = col_end ? col_reg : col_reg + gvn_pkg::COL_W'(1);

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        rot_next = rot_reg;
        if (cfg_hit) begin
            col_next = '0;
            row_next = '0;
        end else if (accept) begin
            if (col_end) begin
                col_next = '0;
                rot_next = gvn_pkg::bank_dec(rot_reg);
                row_next = (row_reg == h_m1) ? '0 : row_reg + gvn_pkg::ROW_W'(1);
            end else begin
                col_next = col_reg + gvn_pkg::COL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_width_reg  <= gvn_pkg::GW_W'(2);
            grid_height_reg <= gvn_pkg::ROW_W'(2);
            col_reg         <= '0;
            row_reg         <= '0;
            rot_reg         <= '0;
            v1_reg          <= 1'b0;
        end else begin
            if (cfg_valid && cfg_index == gvn_pkg::REG_GRID_WIDTH) begin
                grid_width_reg <= cfg_data[gvn_pkg::GW_W-1:0];
            end
            if (cfg_valid && cfg_index == gvn_pkg::REG_GRID_HEIGHT) begin
                grid_height_reg <= cfg_data;
            end
            col_reg <= col_next;
            row_reg <= row_next;
            rot_reg <= rot_next;
            v1_reg  <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            vtx1_reg      <= s_tdata;
            col1_reg      <= col_reg;
            row1_reg      <= row_reg;
            up1_reg       <= (row_reg != '0);
            row_is1_reg   <= (row_reg == gvn_pkg::ROW_W'(1));
            first1_reg    <= (col_reg == '0);
            last1_reg     <= col_end;
            is1_reg       <= (col_reg == gvn_pkg::COL_W'(1));
            drain1_reg    <= (row_reg == h_m1);
            prev_sel1_reg <= gvn_pkg::bank_inc(rot_reg);
            old_sel1_reg  <= gvn_pkg::bank_dec(rot_reg);
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_bank
        gvn_line_ram #(
            .DEPTH(gvn_pkg::MAX_WIDTH),
            .WIDTH(gvn_pkg::VTX_W)
        ) u_ram (
            .aclk  (aclk),
            .we    (accept && rot_reg == 2'(i)),
            .waddr (col_reg),
            .wdata (s_tdata),
            .re    (accept),
            .raddr ((gvn_pkg::bank_inc(rot_reg) == 2'(i)) ? prev_addr : col_reg),
            .rdata (rd[i])
        );
    end

    always_comb begin
        nw_p1   = rd[prev_sel1_reg];
        rd_old  = rd[old_sel1_reg];
        nw_m1   = p0_reg;
        nw_0    = first1_reg ? prev_first_reg : pp1_reg;
        up_ref  = row_is1_reg ? nw_0 : rd_old;
        left_ref = is1_reg ? cur_m1_reg : cur_m2_reg;
    end

    always_ff @(posedge aclk) begin
        if (v1_reg) begin
            p0_reg     <= nw_0;
            pp1_reg    <= nw_p1;
            cur_m2_reg <= cur_m1_reg;
            cur_m1_reg <= vtx1_reg;
            if (first1_reg) begin
                cur_first_reg <= vtx1_reg;
            end
            if (last1_reg) begin
                prev_first_reg <= cur_first_reg;
            end
        end
    end

    always_comb begin
        push_rec.col  = col1_reg;
        push_rec.row  = row1_reg;
        push_rec.mask[gvn_pkg::RES_UP]   = up1_reg;
        push_rec.mask[gvn_pkg::RES_LEFT] = drain1_reg && !first1_reg;
        push_rec.mask[gvn_pkg::RES_SELF] = drain1_reg && last1_reg;

        if (first1_reg) begin
            push_rec.res[gvn_pkg::RES_UP].dx  = gvn_pkg::sub_ext(nw_p1.x, nw_0.x);
            push_rec.res[gvn_pkg::RES_UP].dzx = gvn_pkg::sub_ext(nw_p1.z, nw_0.z);
        end else if (last1_reg) begin
            push_rec.res[gvn_pkg::RES_UP].dx  = gvn_pkg::sub_ext(nw_0.x, nw_m1.x);
            push_rec.res[gvn_pkg::RES_UP].dzx = gvn_pkg::sub_ext(nw_0.z, nw_m1.z);
        end else begin
            push_rec.res[gvn_pkg::RES_UP].dx  = gvn_pkg::sub_ext(nw_p1.x, nw_m1.x);
            push_rec.res[gvn_pkg::RES_UP].dzx = gvn_pkg::sub_ext(nw_p1.z, nw_m1.z);
        end
        push_rec.res[gvn_pkg::RES_UP].dy  = gvn_pkg::sub_ext(vtx1_reg.y, up_ref.y);
        push_rec.res[gvn_pkg::RES_UP].dzy = gvn_pkg::sub_ext(vtx1_reg.z, up_ref.z);

        push_rec.res[gvn_pkg::RES_LEFT].dx  = gvn_pkg::sub_ext(vtx1_reg.x, left_ref.x);
        push_rec.res[gvn_pkg::RES_LEFT].dzx = gvn_pkg::sub_ext(vtx1_reg.z, left_ref.z);
        push_rec.res[gvn_pkg::RES_LEFT].dy  = gvn_pkg::sub_ext(cur_m1_reg.y, nw_m1.y);
        push_rec.res[gvn_pkg::RES_LEFT].dzy = gvn_pkg::sub_ext(cur_m1_reg.z, nw_m1.z);

        push_rec.res[gvn_pkg::RES_SELF].dx  = gvn_pkg::sub_ext(vtx1_reg.x, cur_m1_reg.x);
        push_rec.res[gvn_pkg::RES_SELF].dzx = gvn_pkg::sub_ext(vtx1_reg.z, cur_m1_reg.z);
        push_rec.res[gvn_pkg::RES_SELF].dy  = gvn_pkg::sub_ext(vtx1_reg.y, nw_0.y);
        push_rec.res[gvn_pkg::RES_SELF].dzy = gvn_pkg::sub_ext(vtx1_reg.z, nw_0.z);
    end

    assign push = v1_reg && (push_rec.mask != '0);

endmodule

/* design/gvn_queue.sv */
// Short record queue between the front end and the normal multiplier.
module gvn_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  gvn_pkg::rec_t    push_rec,
    input  logic             pop,
    output gvn_pkg::rec_t    head_rec,
    output gvn_pkg::q_stat_t q_stat
);

    gvn_pkg::rec_t               slot_reg [gvn_pkg::Q_DEPTH];
    logic [gvn_pkg::Q_PTR_W-1:0] wptr_reg, rptr_reg;
    logic [gvn_pkg::Q_LVL_W-1:0] level_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            level_reg <= '0;
        end else begin
            if (push) begin
                wptr_reg <= wptr_reg + gvn_pkg::Q_PTR_W'(1);
            end
            if (pop) begin
                rptr_reg <= rptr_reg + gvn_pkg::Q_PTR_W'(1);
            end
            level_reg <= level_reg + gvn_pkg::Q_LVL_W'(push) - gvn_pkg::Q_LVL_W'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wptr_reg] <= push_rec;
        end
    end

    assign head_rec          = slot_reg[rptr_reg];
    assign q_stat.level      = level_reg;
    assign q_stat.head_valid = (level_reg != '0);

endmodule

/* design/gvn_back.sv */
// Back end: multiplies the differences of each result and holds the output register.
module gvn_back (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  gvn_pkg::rec_t                      head_rec,
    input  gvn_pkg::q_stat_t                   q_stat,
    output logic                               pop,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [gvn_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic                               m_tlast
);

    logic [gvn_pkg::RES_N-1:0]  done_reg, done_next, rem, sel;
    logic                       load, last;
    logic                       valid_reg;
    gvn_pkg::diff_t             d;
    logic signed [gvn_pkg::NORM_W-1:0] nx, ny;
    logic [gvn_pkg::COL_W-1:0]  col;
    logic [gvn_pkg::ROW_W-1:0]  row;
    logic [gvn_pkg::OUT_DATA_W-1:0] data_reg;
    logic                       last_reg;

    assign rem  = head_rec.mask & ~done_reg;
    assign sel  = rem & (~rem + gvn_pkg::RES_N'(1));
    assign last = ((rem & ~sel) == '0);
    assign load = q_stat.head_valid && (!valid_reg || m_tready);
    assign pop  = load && last;

    always_comb begin
        d   = head_rec.res[gvn_pkg::RES_UP];
        col = head_rec.col;
        row = head_rec.row - gvn_pkg::ROW_W'(1);
        if (sel[gvn_pkg::RES_LEFT]) begin
            d   = head_rec.res[gvn_pkg::RES_LEFT];
            col = head_rec.col - gvn_pkg::COL_W'(1);
            row = head_rec.row;
        end else if (sel[gvn_pkg::RES_SELF]) begin
            d   = head_rec.res[gvn_pkg::RES_SELF];
            row = head_rec.row;
        end
    end

    assign nx = d.dy * d.dzx;
    assign ny = d.dx * d.dzy;

    always_comb begin
        done_next = done_reg;
        if (load) begin
            done_next = last ? '0 : (done_reg | sel);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            done_reg  <= '0;
        end else begin
            done_reg <= done_next;
            if (load) begin
                valid_reg <= 1'b1;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= {2'b00, row, col, ny, nx};
            last_reg <= last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

endmodule

/* design/grid_vertex_normal_stencil.sv */
// Top level of the grid vertex normal stencil: heightfield normals by central differences.
// The block takes grid vertices (x, y, z, signed Q8.8) in raster order, one transfer per
// cycle, and returns the normal terms normal_x = dy*dzx and normal_y = dx*dzy as exact
// signed Q18.16 values; the z component is always one and is not sent. Differences are
// central inside the grid and one-sided on the first and last row and column. A vertex of
// row r yields the normal of the same column in row r-1, so the first row gives no
// results; on the last row each vertex also yields the normal of its left neighbor and the
// last vertex yields its own too, so that row drains as it arrives (m_tlast marks the last
// result of one vertex). The input sustains one vertex per cycle while the queue has room;
// the output register passes one result per cycle while m_tready is high, so only last-row
// vertices, with more than one result, slow the input, as the back end has one multiplier
// pair. Three line stores of 1024 vertices rotate as older, previous and current row; they
// need no clearing. Writing grid_width (index 0) or grid_height (index 1) restarts the grid
// at row zero, column zero; width is clamped to 2..1024 and height to at least 2. Configure
// only while the block is idle.
module grid_vertex_normal_stencil (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // vert_x [15:0], vert_y [31:16], vert_z [47:32]
    input  logic [gvn_pkg::VTX_W-1:0]           s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // normal_x [33:0], normal_y [67:34], out_col [77:68], out_row [93:78], zero pad
    output logic [gvn_pkg::OUT_DATA_W-1:0]      m_tdata,
    // run_last
    output logic                                m_tlast,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [gvn_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [gvn_pkg::CFG_DATA_W-1:0]      cfg_data
);

    gvn_pkg::q_stat_t q_stat;
    gvn_pkg::rec_t    push_rec, head_rec;
    logic             push, pop;

    // Register writes are always taken.
    assign cfg_ready = 1'b1;

    // The front end reserves queue room before it accepts a vertex, so records never drop.
    gvn_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_stat    (q_stat),
        .push      (push),
        .push_rec  (push_rec)
    );

    gvn_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .head_rec (head_rec),
        .q_stat   (q_stat)
    );

    gvn_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_rec (head_rec),
        .q_stat   (q_stat),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // The queue never takes a record while full, unless one leaves in the same cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (q_stat.level < gvn_pkg::Q_LVL_W'(gvn_pkg::Q_DEPTH)) || pop)
        else $error("record queue overflow");

    // A record is only removed when one is present.
    assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> q_stat.head_valid)
        else $error("record queue underflow");

    // No result appears in the cycle after reset.
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

endmodule

/* bench/tb_top.sv */
// Self-checking testbench of the grid vertex normal stencil.
`timescale 1ns / 100ps

module tb_top;

    // Expected normal as it should leave the master side.
    typedef struct {
        logic [gvn_pkg::NORM_W-1:0] nx;
        logic [gvn_pkg::NORM_W-1:0] ny;
        logic [gvn_pkg::COL_W-1:0]  col;
        logic [gvn_pkg::ROW_W-1:0]  row;
        logic                       last;
    } normal_t;

    // Scoreboard: keeps its own copy of the three line stores and the grid position,
    // predicts the normals that every accepted vertex releases and checks results in order.
    class normal_board;
        gvn_pkg::vtx_t older[gvn_pkg::MAX_WIDTH];
        gvn_pkg::vtx_t prev[gvn_pkg::MAX_WIDTH];
        gvn_pkg::vtx_t cur[gvn_pkg::MAX_WIDTH];
        int unsigned   col_cnt;
        int unsigned   row_cnt;
        int unsigned   width_reg;
        int unsigned   height_reg;
        normal_t       pending_normals[$];
        int            errors;

        function void clear();
            col_cnt = 0;
            row_cnt = 0;
            width_reg = 2;
            height_reg = 2;
            errors = 0;
            pending_normals.delete();
        endfunction

        function void write_reg(logic [gvn_pkg::CFG_IDX_W-1:0] idx,
                                logic [gvn_pkg::CFG_DATA_W-1:0] value);
            if (idx == gvn_pkg::REG_GRID_WIDTH) begin
                width_reg = value & 16'h07FF;
            end else if (idx == gvn_pkg::REG_GRID_HEIGHT) begin
                height_reg = value;
            end else begin
                return;
            end
            col_cnt = 0;
            row_cnt = 0;
        endfunction

        function void push_normal(int dx, int dzx, int dy, int dzy, int unsigned c,
                                  int unsigned r);
            normal_t n;
            longint px;
            longint py;
            px = longint'(dy) * longint'(dzx);
            py = longint'(dx) * longint'(dzy);
            n.nx = px[gvn_pkg::NORM_W-1:0];
            n.ny = py[gvn_pkg::NORM_W-1:0];
            n.col = c[gvn_pkg::COL_W-1:0];
            n.row = r[gvn_pkg::ROW_W-1:0];
            n.last = 1'b0;
            pending_normals.push_back(n);
        endfunction

        // Notes one accepted vertex and queues the normals it releases.
        function void note_vertex(gvn_pkg::vtx_t v);
            int unsigned   w;
            int unsigned   h;
            int unsigned   c;
            int unsigned   r;
            int unsigned   p;
            int            before_cnt;
            int            dx;
            int            dzx;
            int            dy;
            int            dzy;
            gvn_pkg::vtx_t lft;
            w = (width_reg < 2) ? 2 :
                ((width_reg > gvn_pkg::MAX_WIDTH) ? gvn_pkg::MAX_WIDTH : width_reg);
            h = (height_reg < 2) ? 2 : height_reg;
            c = (col_cnt >= w) ? w - 1 : col_cnt;
            r = row_cnt;
            before_cnt = pending_normals.size();
            if (r >= 1) begin
                // Normal of the row above: its row is complete in the previous store.
                if (c == 0) begin
                    dx = int'(prev[1].x) - int'(prev[0].x);
                    dzx = int'(prev[1].z) - int'(prev[0].z);
                end else if (c == w - 1) begin
                    dx = int'(prev[c].x) - int'(prev[c-1].x);
                    dzx = int'(prev[c].z) - int'(prev[c-1].z);
                end else begin
                    dx = int'(prev[c+1].x) - int'(prev[c-1].x);
                    dzx = int'(prev[c+1].z) - int'(prev[c-1].z);
                end
                if (r == 1) begin
                    dy = int'(v.y) - int'(prev[c].y);
                    dzy = int'(v.z) - int'(prev[c].z);
                end else begin
                    dy = int'(v.y) - int'(older[c].y);
                    dzy = int'(v.z) - int'(older[c].z);
                end
                push_normal(dx, dzx, dy, dzy, c, r - 1);
            end
            if (r == h - 1) begin
                // The last row drains: the left neighbor, and on the last column itself.
                if (c >= 1) begin
                    p = c - 1;
                    lft = (p == 0) ? cur[0] : cur[p-1];
                    dx = int'(v.x) - int'(lft.x);
                    dzx = int'(v.z) - int'(lft.z);
                    dy = int'(cur[p].y) - int'(prev[p].y);
                    dzy = int'(cur[p].z) - int'(prev[p].z);
                    push_normal(dx, dzx, dy, dzy, p, r);
                end
                if (c == w - 1) begin
                    dx = int'(v.x) - int'(cur[c-1].x);
                    dzx = int'(v.z) - int'(cur[c-1].z);
                    dy = int'(v.y) - int'(prev[c].y);
                    dzy = int'(v.z) - int'(prev[c].z);
                    push_normal(dx, dzx, dy, dzy, c, r);
                end
            end
            if (pending_normals.size() > before_cnt) begin
                pending_normals[pending_normals.size()-1].last = 1'b1;
            end
            cur[c] = v;
            c++;
            if (c >= w) begin
                c = 0;
                older = prev;
                prev = cur;
                r++;
                if (r >= h) r = 0;
            end
            col_cnt = c;
            row_cnt = r;
        endfunction

        function void check_normal(logic [gvn_pkg::OUT_DATA_W-1:0] data, logic last);
            normal_t e;
            if (pending_normals.size() == 0) begin
                $error("unexpected result transfer: data=%h last=%b", data, last);
                errors++;
                return;
            end
            e = pending_normals.pop_front();
            if (data[33:0] !== e.nx) begin
                $error("normal_x: expected %h, got %h", e.nx, data[33:0]);
                errors++;
            end
            if (data[67:34] !== e.ny) begin
                $error("normal_y: expected %h, got %h", e.ny, data[67:34]);
                errors++;
            end
            if (data[77:68] !== e.col) begin
                $error("out_col: expected %0d, got %0d", e.col, data[77:68]);
                errors++;
            end
            if (data[93:78] !== e.row) begin
                $error("out_row: expected %0d, got %0d", e.row, data[93:78]);
                errors++;
            end
            if (last !== e.last) begin
                $error("run_last: expected %b, got %b", e.last, last);
                errors++;
            end
        endfunction
    endclass

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 12;

    logic                             aclk = 1'b0;
    logic                             aresetn = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [gvn_pkg::VTX_W-1:0]        s_tdata = '0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [gvn_pkg::OUT_DATA_W-1:0]   m_tdata;
    logic                             m_tlast;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [gvn_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
    logic [gvn_pkg::CFG_DATA_W-1:0]   cfg_data = '0;

    normal_board board = new();
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          quiet_cycles = 0;
    int          grid_no = 0;
    int          random_items = 0;

    always #2 aclk = ~aclk;

    grid_vertex_normal_stencil u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Result side: check every transfer, then decide whether to stall the next cycle.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            board.check_normal(m_tdata, m_tlast);
        end
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // The watchdog counts cycles in which no channel moves a transfer.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Every task starts and ends just after a rising edge.
    task automatic write_cfg(logic [gvn_pkg::CFG_IDX_W-1:0] idx,
                             logic [gvn_pkg::CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        board.write_reg(idx, value);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_vertex(logic [gvn_pkg::COORD_W-1:0] x, logic [gvn_pkg::COORD_W-1:0] y,
                               logic [gvn_pkg::COORD_W-1:0] z);
        gvn_pkg::vtx_t v;
        v.x = x;
        v.y = y;
        v.z = z;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= v;
        do @(posedge aclk); while (!s_tready);
        board.note_vertex(v);
    endtask

    // Waits until every expected normal has come, then lets the pipeline settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (board.pending_normals.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [gvn_pkg::COORD_W-1:0] pick_coord();
        case ($urandom_range(7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            default: return gvn_pkg::COORD_W'($urandom);
        endcase
    endfunction

    // Each grid runs under the next idling mode, so all of them come around.
    task automatic set_idling();
        case (grid_no % 4)
            0: begin send_idle_pct = 0; recv_stall_pct = 0; end
            1: begin send_idle_pct = 49; recv_stall_pct = 0; end
            2: begin send_idle_pct = 0; recv_stall_pct = 49; end
            default: begin send_idle_pct = 12; recv_stall_pct = 12; end
        endcase
        grid_no++;
    endtask

    task automatic random_grid(logic [gvn_pkg::CFG_DATA_W-1:0] w,
                               logic [gvn_pkg::CFG_DATA_W-1:0] h, int count);
        set_idling();
        write_cfg(gvn_pkg::REG_GRID_WIDTH, w);
        write_cfg(gvn_pkg::REG_GRID_HEIGHT, h);
        for (int i = 0; i < count; i++) begin
            send_vertex(pick_coord(), pick_coord(), pick_coord());
        end
        drain();
    endtask

    initial begin
        int w;
        int h;
        int n;
        board.clear();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset values give a 2x2 grid: drive the coordinate extremes straight away.
        send_vertex(16'h8000, 16'h8000, 16'h8000);
        send_vertex(16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_vertex(16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_vertex(16'h8000, 16'h8000, 16'h8000);
        // Grid end: the next vertex wraps to a new grid at row zero.
        send_vertex(16'h7FFF, 16'h8000, 16'h7FFF);
        send_vertex(16'h8000, 16'h7FFF, 16'h8000);
        drain();

        // A 3x3 grid with central differences in the middle, all extremes.
        set_idling();
        write_cfg(gvn_pkg::REG_GRID_WIDTH, 16'd3);
        write_cfg(gvn_pkg::REG_GRID_HEIGHT, 16'd3);
        for (int i = 0; i < 9; i++) begin
            send_vertex(i[0] ? 16'h7FFF : 16'h8000, i[1] ? 16'h8000 : 16'h7FFF,
                        (i % 3 == 1) ? 16'h8000 : 16'h7FFF);
        end
        drain();

        // An unknown register index is ignored.
        write_cfg(gvn_pkg::CFG_IDX_W'(5), 16'hFFFF);

        // Out-of-range settings clamp: width and height below two act as two.
        random_grid(16'd0, 16'd0, 4);
        random_grid(16'd1, 16'd1, 4);
        // An oversized width acts as the maximum: a partial first row, then a restart.
        random_grid(16'hFFFF, 16'd1, 20);
        random_grid(16'd1024, 16'd2, 20);
        // Tallest grid, cut short; the next register write restarts the grid.
        random_grid(16'd2, 16'hFFFF, 9);
        // A partial row followed by a restart.
        random_grid(16'd5, 16'd3, 7);

        // Random grids, mostly complete, sometimes cut short or run past the end.
        while (random_items < 130) begin
            w = $urandom_range(9, 2);
            h = $urandom_range(6, 2);
            if ($urandom_range(3) == 0) begin
                n = $urandom_range(w * h + w, 1);
            end else begin
                n = w * h;
            end
            random_grid(gvn_pkg::CFG_DATA_W'(w), gvn_pkg::CFG_DATA_W'(h), n);
            random_items += n;
        end

        if (board.pending_normals.size() != 0) begin
            $error("%0d expected normals never arrived", board.pending_normals.size());
            board.errors++;
        end
        if (board.errors == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
